>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file cbs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define CBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define CBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cbs_pkg.sv
`timescale 1ns / 1ps

package cbs_pkg;

   localparam int WORD_BITS  = 32;
   localparam int POS_W      = 15;
   localparam int OFF_W      = 10;
   localparam int COUNT_W    = 16;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int MAX_WORDS  = 1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_BIT    = 2'd0,
      CMD_CLEAR_BIT  = 2'd1,
      CMD_WRITE_WORD = 2'd2,
      CMD_CLEAR_ALL  = 2'd3
   } cbs_cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY
   } cbs_state_type;

   typedef struct packed {
      logic                   write;
      logic [WORD_BITS-1:0]   word;
      logic [COUNT_W-1:0]     total;
      logic                   changed;
   } cbs_mod_type;

   function automatic logic [5:0] cbs_popcount(input logic [WORD_BITS-1:0] w);
      logic [31:0] s1;
      logic [31:0] s2;
      logic [31:0] s3;
      logic [7:0]  s4;
      s1 = w - ((w >> 1) & 32'h5555_5555);
      s2 = (s1 & 32'h3333_3333) + ((s1 >> 2) & 32'h3333_3333);
      s3 = (s2 + (s2 >> 4)) & 32'h0F0F_0F0F;
      s4 = s3[7:0] + s3[15:8] + s3[23:16] + s3[31:24];
      return s4[5:0];
   endfunction

endpackage

>>> rtl/counted_bitmap_store_unit.sv
`timescale 1ns / 1ps

// Bitmap page of 32-bit words with a running count of its set bits.
// req channel: one beat per command. req_tuser carries the command (set bit,
// clear bit, write word, clear all); req_tdata carries bit position, word
// offset and word value. rsp channel: one beat per command with the count
// after the command and the changed (dirty) flag.
// For bit and word commands the response is registered when the command
// commits from ST_MODIFY, after the read-modify-write of one word in the
// page memory (read, then write back); no new command is taken until then.
// Clear all sweeps the page memory one word per cycle, then responds from ST_MODIFY.
// Reset: the same sweep runs after reset; req_tready stays low until the
// sweep ends, then the page reads all zeros, count zero.
// Stall: a response waits in the output register while rsp_tready is low;
// the next request is still taken and holds before write-back until the
// output register frees up.
module counted_bitmap_store_unit import cbs_pkg::*; #(
   parameter int PAGE_WORDS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [14:0] bit_position, [24:15] word_offset, [56:25] word_value, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] set_count, [16] changed, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int MemDepth = (PAGE_WORDS < MAX_WORDS) ? PAGE_WORDS : MAX_WORDS;
   localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

   cbs_state_type        state_ff, state_in;
   logic [AddrW-1:0]     sweep_ff, sweep_in;
   logic                 clr_pending_ff, clr_pending_in;
   cbs_cmd_type          cmd_ff, cmd_in;
   logic [4:0]           bit_ff, bit_in;
   logic [WORD_BITS-1:0] value_ff, value_in;
   logic [AddrW-1:0]     addr_ff, addr_in;
   logic                 in_range_ff, in_range_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_changed_ff, rsp_changed_in;

   cbs_cmd_type          req_cmd;
   logic [POS_W-1:0]     req_pos;
   logic [OFF_W-1:0]     req_off;
   logic [OFF_W-1:0]     req_widx;
   logic                 req_beat;
   logic                 slot_free;
   logic                 commit;

   logic                 mem_we;
   logic [AddrW-1:0]     mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] mem_rdata;
   cbs_mod_type          mod;

   assign req_cmd  = cbs_cmd_type'(req_tuser);
   assign req_pos  = req_tdata[POS_W-1:0];
   assign req_off  = req_tdata[POS_W+OFF_W-1:POS_W];
   assign req_widx = (req_cmd == CMD_SET_BIT || req_cmd == CMD_CLEAR_BIT)
                     ? req_pos[POS_W-1:5] : req_off;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_MODIFY) && slot_free;

   cbs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MemDepth)
   ) u_page (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_beat),
      .rd_addr (req_widx[AddrW-1:0]),
      .rd_data (mem_rdata)
   );

   cbs_modify u_modify (
      .cmd      (cmd_ff),
      .in_range (in_range_ff),
      .bit_sel  (bit_ff),
      .value    (value_ff),
      .old_word (mem_rdata),
      .total    (total_ff),
      .mod      (mod)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = mod.word;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = '0;
      end else if (commit) begin
         mem_we = mod.write;
      end
   end

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      clr_pending_in = clr_pending_ff;
      cmd_in         = cmd_ff;
      bit_in         = bit_ff;
      value_in       = value_ff;
      addr_in        = addr_ff;
      in_range_in    = in_range_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_changed_in = rsp_changed_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = AddrW'(sweep_ff + 1'b1);
            if (sweep_ff == AddrW'(MemDepth - 1)) begin
               sweep_in       = '0;
               clr_pending_in = 1'b0;
               state_in       = clr_pending_ff ? ST_MODIFY : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               cmd_in      = req_cmd;
               bit_in      = req_pos[4:0];
               value_in    = req_tdata[POS_W+OFF_W+WORD_BITS-1:POS_W+OFF_W];
               addr_in     = req_widx[AddrW-1:0];
               in_range_in = (32'(req_widx) < PAGE_WORDS);
               if (req_cmd == CMD_CLEAR_ALL) begin
                  state_in       = ST_CLEAR;
                  sweep_in       = '0;
                  clr_pending_in = 1'b1;
                  total_in       = '0;
               end else begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            if (commit) begin
               total_in       = mod.total;
               rsp_valid_in   = 1'b1;
               rsp_count_in   = mod.total;
               rsp_changed_in = mod.changed;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         sweep_ff       <= '0;
         clr_pending_ff <= 1'b0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         clr_pending_ff <= clr_pending_in;
         total_ff       <= total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      bit_ff         <= bit_in;
      value_ff       <= value_in;
      addr_ff        <= addr_in;
      in_range_ff    <= in_range_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-COUNT_W-1){1'b0}}, rsp_changed_ff, rsp_count_ff};

endmodule

>>> rtl/cbs_ram.sv
`timescale 1ns / 1ps

module cbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cbs_modify.sv
`timescale 1ns / 1ps

module cbs_modify import cbs_pkg::*; (
   input  cbs_cmd_type          cmd,
   input  logic                 in_range,
   input  logic [4:0]           bit_sel,
   input  logic [WORD_BITS-1:0] value,
   input  logic [WORD_BITS-1:0] old_word,
   input  logic [COUNT_W-1:0]   total,
   output cbs_mod_type          mod
);

   logic [WORD_BITS-1:0] mask;
   logic                 is_set;
   logic [COUNT_W-1:0]   pop_old;
   logic [COUNT_W-1:0]   pop_new;

   always_comb begin
      mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
      is_set  = old_word[bit_sel];
      pop_old = COUNT_W'(cbs_popcount(old_word));
      pop_new = COUNT_W'(cbs_popcount(value));

      mod.write   = 1'b0;
      mod.word    = old_word;
      mod.total   = total;
      mod.changed = 1'b0;

      unique case (cmd)
         CMD_SET_BIT: begin
            if (in_range && !is_set) begin
               mod.write   = 1'b1;
               mod.word    = old_word | mask;
               mod.total   = total + 1'b1;
               mod.changed = 1'b1;
            end
         end
         CMD_CLEAR_BIT: begin
            if (in_range && is_set) begin
               mod.write   = 1'b1;
               mod.word    = old_word & ~mask;
               mod.total   = total - 1'b1;
               mod.changed = 1'b1;
            end
         end
         CMD_WRITE_WORD: begin
            if (in_range) begin
               mod.write   = 1'b1;
               mod.word    = value;
               mod.total   = total - pop_old + pop_new;
               mod.changed = 1'b1;
            end
         end
         CMD_CLEAR_ALL: begin
            mod.total   = '0;
            mod.changed = 1'b1;
         end
         default: begin
            mod.write = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/cbs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // hold a stalled response beat
   `CBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped under stall")

   // hold the data of a stalled response beat
   `CBS_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp data moved")

   // take one command at a time
   `CBS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "req taken while a command is in flight")

   // block requests while the page is swept after reset
   `CBS_ASSERT_SAME(a_sweep_after_reset, clock, reset, $past(reset), !req_tready, "req taken before the page sweep")

endmodule

bind counted_bitmap_store_unit cbs_checker u_cbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
